[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wsfd_pkg.sv]
// Types and constants for the WebSocket frame deframer.
// No dependencies; imported by every wsfd module and the checker.
`default_nettype none
package wsfd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [15:0] frame_length;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic      valid;
    res_item_t item;
  } res_push_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_KEY,
    PH_DATA,
    PH_DROP
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
  localparam logic [1:0] STATUS_LEN64     = 2'd2;
  localparam logic [1:0] STATUS_OVER_MAX  = 2'd3;

  localparam logic [7:0] HDR0_REQ_BITS = 8'h81;  // FIN and opcode bit 0
  localparam logic [6:0] LEN7_MAX      = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
  localparam int          APB_DATA_W        = 32;
  localparam int          APB_ADDR_W        = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_PAYLOAD = 2'd0;

endpackage
`default_nettype wire

[hw/rtl/wsfd_regs.sv]
// APB configuration register block (max_payload).
// Depends on wsfd_pkg.
`default_nettype none
module wsfd_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wsfd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wsfd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [15:0]                      max_payload
);
  import wsfd_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == ADDR_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (wr_hit) begin
      max_payload <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MAX_PAYLOAD) begin
      prdata = {{(APB_DATA_W-16){1'b0}}, max_payload};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wsfd_parse.sv]
// Input register plus frame header/payload state machine.
// Depends on wsfd_pkg; drives at most one result push per advanced byte.
`default_nettype none
module wsfd_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  wsfd_pkg::byte_item_t byte_item,
  input  logic [15:0]          max_payload,
  input  logic                 res_free,
  output wsfd_pkg::res_push_t  push
);
  import wsfd_pkg::*;

  logic       s1_valid;
  byte_item_t s1_item;
  logic       s1_adv;

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;

  logic [7:0]  b;
  logic [15:0] ext_len;
  logic [15:0] rem_dec;
  logic [7:0]  key_byte;

  assign s1_adv     = s1_valid && res_free;
  assign byte_ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_count   <= '0;
      length_high    <= '0;
      payload_length <= '0;
      remaining      <= '0;
      mask_key       <= '0;
      key_index      <= '0;
    end else if (s1_adv) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      length_high    <= length_high_next;
      payload_length <= payload_length_next;
      remaining      <= remaining_next;
      mask_key       <= mask_key_next;
      key_index      <= key_index_next;
    end
  end

  assign b        = s1_item.data_byte;
  assign ext_len  = {length_high, b};
  assign rem_dec  = remaining - 16'd1;
  assign key_byte = mask_key[{key_index, 3'b000} +: 8];

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_high_next    = length_high;
    payload_length_next = payload_length;
    remaining_next      = remaining;
    mask_key_next       = mask_key;
    key_index_next      = key_index;
    push                = '0;

    if (s1_item.frame_start) begin
      // a new frame always restarts the parser
      header_count_next = '0;
      key_index_next    = '0;
      remaining_next    = '0;
      if ((b & HDR0_REQ_BITS) != HDR0_REQ_BITS) begin
        phase_next         = PH_DROP;
        push.valid         = 1'b1;
        push.item.kind     = KIND_ERROR;
        push.item.status   = STATUS_BAD_HDR;
        push.item.last     = 1'b1;
      end else begin
        phase_next = PH_LEN;
      end
    end else begin
      case (phase)
        PH_LEN: begin
          if (!b[7]) begin
            // unmasked client frame
            phase_next       = PH_DROP;
            push.valid       = 1'b1;
            push.item.kind   = KIND_ERROR;
            push.item.status = STATUS_BAD_HDR;
            push.item.last   = 1'b1;
          end else if (b[6:0] <= LEN7_MAX) begin
            payload_length_next = {9'd0, b[6:0]};
            header_count_next   = '0;
            phase_next          = PH_KEY;
          end else if (b[6:0] == LEN_CODE_16) begin
            phase_next = PH_EXT_HI;
          end else begin
            phase_next       = PH_DROP;
            push.valid       = 1'b1;
            push.item.kind   = KIND_ERROR;
            push.item.status = STATUS_LEN64;
            push.item.last   = 1'b1;
          end
        end
        PH_EXT_HI: begin
          length_high_next = b;
          phase_next       = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          if (ext_len >= max_payload) begin
            phase_next       = PH_DROP;
            push.valid       = 1'b1;
            push.item.kind   = KIND_ERROR;
            push.item.status = STATUS_OVER_MAX;
            push.item.last   = 1'b1;
          end else begin
            payload_length_next = ext_len;
            header_count_next   = '0;
            phase_next          = PH_KEY;
          end
        end
        PH_KEY: begin
          mask_key_next[{header_count, 3'b000} +: 8] = b;
          if (header_count == 2'd3) begin
            header_count_next = '0;
            key_index_next    = '0;
            if (payload_length == 16'd0) begin
              phase_next     = PH_IDLE;
              push.valid     = 1'b1;
              push.item.kind = KIND_EMPTY;
              push.item.last = 1'b1;
            end else begin
              remaining_next = payload_length;
              phase_next     = PH_DATA;
            end
          end else begin
            header_count_next = header_count + 2'd1;
          end
        end
        PH_DATA: begin
          key_index_next         = key_index + 2'd1;
          remaining_next         = rem_dec;
          push.valid             = 1'b1;
          push.item.kind         = KIND_PAYLOAD;
          push.item.payload_byte = b ^ key_byte;
          if (rem_dec == 16'd0) begin
            phase_next             = PH_IDLE;
            push.item.frame_length = payload_length;
            push.item.last         = 1'b1;
          end
        end
        default: begin
          // idle or dropping: byte is discarded
        end
      endcase
    end

    push.valid = push.valid && s1_valid;
  end

endmodule
`default_nettype wire

[hw/rtl/wsfd_out.sv]
// Result register on the output channel.
// Depends on wsfd_pkg; fed by wsfd_parse.
`default_nettype none
module wsfd_out (
  input  logic                clk,
  input  logic                rst,
  input  wsfd_pkg::res_push_t push,
  output logic                res_free,
  output logic                res_valid,
  input  logic                res_ready,
  output wsfd_pkg::res_item_t res_item
);
  import wsfd_pkg::*;

  assign res_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && push.valid) begin
      res_item <= push.item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/websocket_frame_deframer_core.sv]
// Top level of the WebSocket client frame deframer (RFC 6455 subset).
// Depends on wsfd_pkg, wsfd_regs, wsfd_parse, wsfd_out.
//
//   channel   handshake              payload              direction
//   byte      byte_valid/byte_ready  byte_item_t          in, one frame byte
//   res       res_valid/res_ready    res_item_t           out, zero or one per byte
//   config    psel/penable/pwrite    paddr/pwdata/prdata  APB, max_payload at 0x0
//
// One byte is accepted every cycle unless a stalled result backs up to byte_ready;
// a byte's result reaches res through the input register, then the result register.
// The state update and unmasking XOR sit between those two registers.
// rst is synchronous: parser goes idle, key and lengths clear, max_payload = 1024.
// A stalled result holds the result register and the input register; byte_ready
// drops only when both are full.
`default_nettype none
module websocket_frame_deframer_core (
  input  logic                             clk,
  input  logic                             rst,
  // byte stream
  input  logic                             byte_valid,
  output logic                             byte_ready,
  input  wsfd_pkg::byte_item_t             byte_item,
  // results
  output logic                             res_valid,
  input  logic                             res_ready,
  output wsfd_pkg::res_item_t              res_item,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wsfd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wsfd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import wsfd_pkg::*;

  logic [15:0] max_payload;
  logic        res_free;   // result register can take a new push this cycle
  res_push_t   push;

  wsfd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  // header parse, mask key capture and payload unmasking
  wsfd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .max_payload (max_payload),
    .res_free    (res_free),
    .push        (push)
  );

  wsfd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire

[hw/rtl/wsfd_checker.sv]
// Port-level checker for websocket_frame_deframer_core, with its bind.
// Depends on wsfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wsfd_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input wsfd_pkg::res_item_t res_item
);
  import wsfd_pkg::*;

  `ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `ASSERT_IMP(a_err_fields, res_valid && res_item.kind == KIND_ERROR, res_item.last && res_item.frame_length == 16'd0 && res_item.payload_byte == 8'd0, "bad error result")
  `ASSERT_IMP(a_empty_fields, res_valid && res_item.kind == KIND_EMPTY, res_item.last && res_item.status == STATUS_OK && res_item.frame_length == 16'd0, "bad empty result")
  `ASSERT_IMP(a_kind_status, res_valid && res_item.kind != KIND_ERROR, res_item.status == STATUS_OK && (res_item.kind == KIND_PAYLOAD || res_item.kind == KIND_EMPTY), "bad kind or status")
  `ASSERT_IMP(a_mid_len, res_valid && !res_item.last, res_item.kind == KIND_PAYLOAD && res_item.frame_length == 16'd0, "length on non-final result")

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);
`default_nettype wire
